// ===== rtl/core/sha1md_pkg.sv =====
package sha1md_pkg;

	// One input item: a message byte and/or the end mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} item_t;

	// One result item: a digest word and its place
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} result_t;

	localparam logic [2:0] LAST_INDEX = 3'd4;

	// Initial chaining values
	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	// Round constants, one per group of twenty rounds
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

// ===== rtl/core/sha1md_fifo.sv =====
module sha1md_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/sha1md_front.sv =====
module sha1md_front import sha1md_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  item_t item,
	input  logic  cmd_pop,
	output item_t cmd,
	output logic  cmd_empty
);

	localparam int IW = $bits(item_t);

	logic          keep;
	logic [IW-1:0] cmd_bits;

	// Items with neither byte nor end mark change nothing: drop them here
	assign keep = item.byte_valid | item.end_of_message;

	sha1md_fifo #(.W(IW), .DEPTH(DEPTH)) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push & keep),
		.din   (item),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (cmd_bits),
		.empty (cmd_empty)
	);

	assign cmd = item_t'(cmd_bits);

endmodule

// ===== rtl/core/sha1md_core.sv =====
module sha1md_core import sha1md_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   cmd,
	input  logic    cmd_empty,
	output logic    cmd_pop,
	output logic    res_push,
	output result_t res,
	input  logic    res_full
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PAD   = 3'd1;
	localparam logic [2:0] S_FILL  = 3'd2;
	localparam logic [2:0] S_LEN   = 3'd3;
	localparam logic [2:0] S_ROUND = 3'd4;
	localparam logic [2:0] S_ADD   = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	localparam logic [6:0] LAST_ROUND = 7'd79;

	logic [2:0]  state_q, ret_q, state_d, ret_d;
	logic [31:0] sched_q [16];
	logic [31:0] chain_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [23:0] acc_q;
	logic [60:0] count_q;
	logic [3:0]  wcnt_q;
	logic [6:0]  rnd_q;
	logic [2:0]  oidx_q;

	logic        app_en, go_round, take_byte, out_done;
	logic [31:0] app_word, pad_word, f, k, t, w_next;

	// Command fetch and result push
	assign cmd_pop   = (state_q == S_IDLE) & ~cmd_empty;
	assign take_byte = cmd_pop & cmd.byte_valid;
	assign res_push  = (state_q == S_OUT) & ~res_full;
	assign out_done  = res_push & (oidx_q == LAST_INDEX);
	assign res.digest_word = chain_q[oidx_q];
	assign res.word_index  = oidx_q;
	assign res.last_word   = (oidx_q == LAST_INDEX);

	// Padding word: bytes held so far, then 0x80, then zeros
	always_comb begin
		case (count_q[1:0])
			2'd0:    pad_word = {PAD_BYTE, 24'h0};
			2'd1:    pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
			2'd2:    pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
			2'd3:    pad_word = {acc_q[23:0], PAD_BYTE};
			default: pad_word = {PAD_BYTE, 24'h0};
		endcase
	end

	// Round function and schedule expansion
	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K3;
		end
		t = {a_q[26:0], a_q[31:27]} + f + e_q + k + sched_q[0];
		w_next = sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0];
		w_next = {w_next[30:0], w_next[31]};
	end

	// Sequencer: which word goes into the block and where to go next
	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		app_en   = 1'b0;
		app_word = '0;
		go_round = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_pop) begin
					if (take_byte && count_q[1:0] == 2'd3) begin
						app_en   = 1'b1;
						app_word = {acc_q, cmd.data_byte};
					end
					if (app_en && wcnt_q == 4'd15) begin
						go_round = 1'b1;
						ret_d    = cmd.end_of_message ? S_PAD : S_IDLE;
					end else if (cmd.end_of_message) begin
						state_d = S_PAD;
					end
				end
			end
			S_PAD: begin
				app_en   = 1'b1;
				app_word = pad_word;
				if (wcnt_q == 4'd15) begin
					go_round = 1'b1;
					ret_d    = S_FILL;
				end else begin
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				app_en = 1'b1;
				if (wcnt_q == 4'd14) begin
					app_word = count_q[60:29];
					state_d  = S_LEN;
				end else if (wcnt_q == 4'd15) begin
					go_round = 1'b1;
					ret_d    = S_FILL;
				end
			end
			S_LEN: begin
				app_en   = 1'b1;
				app_word = {count_q[28:0], 3'b000};
				go_round = 1'b1;
				ret_d    = S_OUT;
			end
			S_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				state_d = ret_q;
			end
			S_OUT: begin
				if (out_done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (go_round) begin
			state_d = S_ROUND;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			count_q <= '0;
			wcnt_q  <= '0;
			rnd_q   <= '0;
			oidx_q  <= '0;
			chain_q <= '{IV0, IV1, IV2, IV3, IV4};
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (take_byte) begin
				count_q <= count_q + 61'd1;
			end
			if (app_en) begin
				wcnt_q <= wcnt_q + 4'd1;
			end
			if (go_round) begin
				rnd_q <= '0;
			end else if (state_q == S_ROUND) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (state_q == S_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (res_push) begin
				oidx_q <= out_done ? 3'd0 : oidx_q + 3'd1;
			end
			// Digest delivered: ready for the next message
			if (out_done) begin
				chain_q <= '{IV0, IV1, IV2, IV3, IV4};
				count_q <= '0;
				wcnt_q  <= '0;
			end
		end
	end

	// Block shift line, byte packer and working registers
	always_ff @(posedge clk) begin
		if (take_byte) begin
			acc_q <= {acc_q[15:0], cmd.data_byte};
		end
		if (app_en) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= app_word;
		end else if (state_q == S_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= w_next;
		end
		if (go_round) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == S_ROUND) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

// ===== rtl/core/sha1_message_digest.sv =====
// SHA-1 digest of a byte stream.
// Input channel (push/full): one item per message byte; an item with
// byte_valid low and end_of_message high ends a message without a byte,
// items with both low are accepted and dropped. A byte and an end mark may
// share an item; the byte is taken first.
// Result channel (empty/pop): after each message the five digest words
// come out in order, word_index 0..4, last_word high on the fifth.
// Flow: while idle, the engine takes one queued byte per cycle; it takes
// none while a 64-byte block is compressed (80 rounds on one shared
// round unit, then an add into the chaining words). After the end mark,
// padding runs around one or two block compressions, then the five
// words are pushed in order while the result queue has room. The
// command queue (CMD_DEPTH items) keeps taking items while a block is
// compressed; full rises only when it is filled.
// Reset clears both queues and loads the initial chaining values.
// If the receiver stalls, the result queue (OUT_DEPTH words) fills and the
// engine waits; input items keep queuing until the command queue is full.
module sha1_message_digest import sha1md_pkg::*; #(
	parameter int CMD_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    full,
	input  item_t   item,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	localparam int RW = $bits(result_t);

	item_t         cmd;
	logic          cmd_empty, cmd_pop;
	result_t       res;
	logic          res_push, res_full;
	logic [RW-1:0] res_bits;

	sha1md_front #(.DEPTH(CMD_DEPTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	sha1md_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full)
	);

	sha1md_fifo #(.W(RW), .DEPTH(OUT_DEPTH)) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_bits),
		.empty (empty)
	);

	assign result = result_t'(res_bits);

endmodule

// ===== rtl/core/sha1md_checker.sv =====
module sha1md_checker import sha1md_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    empty,
	input logic    pop,
	input result_t result
);

	// Last mark sits exactly on the fifth word
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.last_word == (result.word_index == LAST_INDEX)))
		else $error("last_word does not match word_index");

	// Word index stays in range
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.word_index <= LAST_INDEX))
		else $error("word_index out of range");

	// Digest words follow one another without gaps
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last_word) ##1 !empty
		|-> (result.word_index == $past(result.word_index) + 3'd1))
		else $error("digest word skipped or repeated");

	// A waiting item holds while not taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("result changed while stalled");

endmodule

bind sha1_message_digest sha1md_checker u_sha1md_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.empty (empty),
	.pop   (pop),
	.result(result)
);

// ===== sim/tb_sha1_message_digest.sv =====
module tb_sha1_message_digest;
	import sha1md_pkg::*;

	localparam int NUM_ITEMS   = 320;
	localparam int STALL_PCT   = 37;
	localparam int HOLD_CYCLES = 300;
	localparam int WDOG_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 400;
	localparam int BUF_DEPTH   = 1024;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    push = 1'b0;
	logic    full;
	item_t   item = '0;
	logic    empty;
	logic    pop = 1'b0;
	result_t result;

	// Predictor state
	logic [31:0] chain_q [5];
	logic [31:0] block_q [16];
	logic [60:0] byte_cnt;

	// Pending items and expected words, each with write and read counts
	item_t   pend_mem [BUF_DEPTH];
	result_t exp_mem [BUF_DEPTH];
	int pend_wr;
	int pend_rd;
	int exp_wr;
	int exp_rd;

	int n_items;
	int n_sent;
	int n_msgs;
	int n_bytes;
	int words_seen;
	int errors;
	int hold_left;
	bit hold_done;
	int wdog_cnt;

	sha1_message_digest i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// 80-round compression of block_q into chain_q
	function automatic void compress_block();
		logic [31:0] sched [16];
		logic [31:0] a, b, c, d, e, f, k, x, t;
		int r;
		for (r = 0; r < 16; r++)
			sched[r] = block_q[r];
		a = chain_q[0];
		b = chain_q[1];
		c = chain_q[2];
		d = chain_q[3];
		e = chain_q[4];
		for (r = 0; r < 80; r++) begin
			if (r < 16) begin
				x = sched[r];
			end else begin
				x = sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^
				    sched[(r + 2) % 16] ^ sched[r % 16];
				x = {x[30:0], x[31]};
				sched[r % 16] = x;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + x;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_q[0] += a;
		chain_q[1] += b;
		chain_q[2] += c;
		chain_q[3] += d;
		chain_q[4] += e;
	endfunction

	// Big-endian byte placement; first byte of a word clears the rest
	function automatic void put_byte(logic [5:0] pos, logic [7:0] b);
		if (pos[1:0] == 2'd0)
			block_q[pos[5:2]] = {b, 24'h0};
		else
			block_q[pos[5:2]] |= {24'h0, b} << (24 - 8 * pos[1:0]);
	endfunction

	// Take one accepted item; an end mark pads, finishes and queues the digest
	function automatic void absorb_item(item_t it);
		logic [5:0]  pos;
		logic [63:0] bits;
		int          p;
		int          i;
		result_t     r;
		if (it.byte_valid) begin
			pos = byte_cnt[5:0];
			put_byte(pos, it.data_byte);
			byte_cnt = byte_cnt + 61'd1;
			n_bytes++;
			if (pos == 6'd63)
				compress_block();
		end
		if (!it.end_of_message)
			return;
		bits = {byte_cnt, 3'b000};
		p = int'(byte_cnt[5:0]);
		put_byte(p[5:0], PAD_BYTE);
		p++;
		if (p % 4 != 0)
			p = (p | 3) + 1;
		// no room for the length: extra block
		if (p > 56) begin
			for (i = p / 4; i < 16; i++)
				block_q[i] = '0;
			compress_block();
			p = 0;
		end
		for (i = p / 4; i < 14; i++)
			block_q[i] = '0;
		block_q[14] = bits[63:32];
		block_q[15] = bits[31:0];
		compress_block();
		for (i = 0; i < 5; i++) begin
			r.digest_word = chain_q[i];
			r.word_index  = 3'(i);
			r.last_word   = (3'(i) == LAST_INDEX);
			exp_mem[exp_wr] = r;
			exp_wr++;
		end
		chain_q  = '{IV0, IV1, IV2, IV3, IV4};
		byte_cnt = '0;
		n_msgs++;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("MISMATCH %s: got %h expected %h (word %0d)", what, got, want,
		         words_seen);
		errors++;
	endtask

	task automatic add_item(input logic [7:0] b, input logic v, input logic e);
		item_t it;
		it.data_byte      = b;
		it.byte_valid     = v;
		it.end_of_message = e;
		pend_mem[pend_wr] = it;
		pend_wr++;
		if (v || e)
			n_items++;
	endtask

	// One message of len bytes, with stray empty items and either end style
	task automatic queue_message(input int len);
		int i;
		bit sep_end;
		sep_end = (len == 0) || ($urandom_range(1) == 1);
		for (i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				add_item(8'($urandom_range(255)), 1'b0, 1'b0);
			add_item(8'($urandom_range(255)), 1'b1, !sep_end && (i == len - 1));
		end
		if (sep_end)
			add_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	// Driver: offer the oldest pending item, hold it until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				absorb_item(item);
				pend_rd++;
				n_sent++;
			end
			if (!(push && full)) begin
				if (pend_rd < pend_wr &&
				    ((n_sent >= 100 && n_sent < 180) ||
				     $urandom_range(99) >= STALL_PCT)) begin
					push <= 1'b1;
					item <= pend_mem[pend_rd];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each taken word against the oldest expected one
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (exp_rd == exp_wr) begin
					report_mismatch("word with none expected", result.digest_word, '0);
				end else begin
					if (result.digest_word !== exp_mem[exp_rd].digest_word)
						report_mismatch("digest_word", result.digest_word,
						                exp_mem[exp_rd].digest_word);
					if (result.word_index !== exp_mem[exp_rd].word_index)
						report_mismatch("word_index", 32'(result.word_index),
						                32'(exp_mem[exp_rd].word_index));
					if (result.last_word !== exp_mem[exp_rd].last_word)
						report_mismatch("last_word", 32'(result.last_word),
						                32'(exp_mem[exp_rd].last_word));
					exp_rd++;
				end
				words_seen++;
			end
			// one long hold-off so both queues fill and full rises
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (!hold_done && words_seen >= 20) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				pop <= 1'b0;
			end else begin
				pop <= (words_seen >= 30 && words_seen < 55) ||
				       ($urandom_range(99) >= STALL_PCT);
			end
		end
	end

	// Watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				wdog_cnt <= 0;
			else
				wdog_cnt <= wdog_cnt + 1;
			if (wdog_cnt >= WDOG_LIMIT) begin
				$display("Timeout: no progress for %0d cycles", WDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int pad_lens [5];
		int i;
		pad_lens = '{55, 56, 57, 63, 64};
		chain_q  = '{IV0, IV1, IV2, IV3, IV4};
		for (i = 0; i < 16; i++)
			block_q[i] = '0;
		byte_cnt   = '0;
		pend_wr    = 0;
		pend_rd    = 0;
		exp_wr     = 0;
		exp_rd     = 0;
		n_items    = 0;
		n_sent     = 0;
		n_msgs     = 0;
		n_bytes    = 0;
		words_seen = 0;
		errors     = 0;
		hold_left  = 0;
		hold_done  = 1'b0;
		wdog_cnt   = 0;

		// directed: empty message, stray item, "abc", extreme bytes, both end styles
		add_item(8'hFF, 1'b0, 1'b1);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'h61, 1'b1, 1'b0);
		add_item(8'h62, 1'b1, 1'b0);
		add_item(8'h63, 1'b1, 1'b1);
		add_item(8'h00, 1'b1, 1'b0);
		add_item(8'h5A, 1'b0, 1'b1);
		add_item(8'hFF, 1'b1, 1'b1);
		add_item(8'h80, 1'b1, 1'b0);
		add_item(8'hA5, 1'b0, 1'b0);
		add_item(8'h7F, 1'b1, 1'b1);
		add_item(8'h00, 1'b0, 1'b1);
		add_item(8'h00, 1'b0, 1'b1);

		// lengths around the padding boundaries, then short messages
		for (i = 0; i < 5; i++)
			queue_message(pad_lens[i]);
		while (n_items < NUM_ITEMS)
			queue_message($urandom_range(12));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (pend_rd == pend_wr && !push && exp_rd == exp_wr);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (exp_rd != exp_wr)
			report_mismatch("words never seen", 32'(exp_wr - exp_rd), '0);

		$display("Ran %0d items: %0d messages, %0d bytes, %0d digest words checked",
		         n_sent, n_msgs, n_bytes, words_seen);
		$display("Included empty and padding-boundary messages and a long output stall");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
